### sv/zatr_pkg.sv
// Shared types, codes and character constants of the zone alarm reporter.
package zatr_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_TRIGGER = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_SWEEP   = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SWEEP_LOW   = 2'd0;
	localparam logic [1:0] CFG_SWEEP_HIGH  = 2'd1;
	localparam logic [1:0] CFG_SWEEP_START = 2'd2;

	// Reset values of the sweep registers.
	localparam logic [7:0] SWEEP_LOW_RESET   = 8'd50;
	localparam logic [7:0] SWEEP_HIGH_RESET  = 8'd150;
	localparam logic [7:0] SWEEP_START_RESET = 8'd100;

	// Command queue geometry.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Index of the final character of the sixteen-character report.
	localparam logic [3:0] REPORT_LAST = 4'd15;

	// ASCII characters of the report.
	localparam logic [7:0] CHR_Z     = 8'h5A;
	localparam logic [7:0] CHR_O     = 8'h4F;
	localparam logic [7:0] CHR_N     = 8'h4E;
	localparam logic [7:0] CHR_A     = 8'h41;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_CR    = 8'h0D;

	// Time of day held as BCD digits.
	typedef struct packed {
		logic [1:0] hr_hi;
		logic [3:0] hr_lo;
		logic [2:0] mn_hi;
		logic [3:0] mn_lo;
		logic [2:0] sc_hi;
		logic [3:0] sc_lo;
	} tod_t;

	// One command from the front end to the back end.
	typedef struct packed {
		logic       is_report;
		logic [1:0] zone;
		tod_t       tod;
		logic       siren_on;
		logic [7:0] period;
		logic       alarm;
	} cmd_t;

	// Character at position idx of the report for the given command.
	function automatic logic [7:0] report_char(input cmd_t cmd, input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = CHR_Z;
			4'd1:    ch = CHR_O;
			4'd2:    ch = CHR_N;
			4'd3:    ch = CHR_A;
			4'd4:    ch = CHR_SPACE;
			4'd5:    ch = CHR_ZERO + {6'd0, cmd.zone};
			4'd6:    ch = CHR_SPACE;
			4'd7:    ch = CHR_ZERO + {6'd0, cmd.tod.hr_hi};
			4'd8:    ch = CHR_ZERO + {4'd0, cmd.tod.hr_lo};
			4'd9:    ch = CHR_COLON;
			4'd10:   ch = CHR_ZERO + {5'd0, cmd.tod.mn_hi};
			4'd11:   ch = CHR_ZERO + {4'd0, cmd.tod.mn_lo};
			4'd12:   ch = CHR_COLON;
			4'd13:   ch = CHR_ZERO + {5'd0, cmd.tod.sc_hi};
			4'd14:   ch = CHR_ZERO + {4'd0, cmd.tod.sc_lo};
			default: ch = CHR_CR;
		endcase
		return ch;
	endfunction

endpackage

### sv/zatr_front.sv
// Front end: accepts items, keeps time, alarm and sweep state, queues commands.
module zatr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [1:0]         zone,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output logic               push,
	output zatr_pkg::cmd_t     push_data,
	input  logic               full
);

	zatr_pkg::tod_t tod_q;
	logic           alarm_q;
	logic [7:0]     sweep_low_q;
	logic [7:0]     sweep_high_q;
	logic [7:0]     period_q;
	logic           rising_q;
	logic           accept;
	logic           rising_next;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	assign push = accept && (opcode == zatr_pkg::OP_TRIGGER || opcode == zatr_pkg::OP_SWEEP);

	always_comb begin
		if (period_q > sweep_high_q) begin
			rising_next = 1'b0;
		end else if (period_q < sweep_low_q) begin
			rising_next = 1'b1;
		end else begin
			rising_next = rising_q;
		end
	end

	always_comb begin
		push_data           = '0;
		push_data.is_report = (opcode == zatr_pkg::OP_TRIGGER);
		push_data.zone      = zone;
		push_data.tod       = tod_q;
		if (opcode == zatr_pkg::OP_TRIGGER) begin
			push_data.alarm = 1'b1;
		end else begin
			push_data.alarm    = alarm_q;
			push_data.siren_on = alarm_q;
			push_data.period   = alarm_q ? period_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q        <= '0;
			alarm_q      <= 1'b0;
			sweep_low_q  <= zatr_pkg::SWEEP_LOW_RESET;
			sweep_high_q <= zatr_pkg::SWEEP_HIGH_RESET;
			period_q     <= zatr_pkg::SWEEP_START_RESET;
			rising_q     <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					zatr_pkg::CFG_SWEEP_LOW:   sweep_low_q  <= cfg_data;
					zatr_pkg::CFG_SWEEP_HIGH:  sweep_high_q <= cfg_data;
					zatr_pkg::CFG_SWEEP_START: period_q     <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				case (opcode)
					zatr_pkg::OP_TRIGGER: begin
						alarm_q <= 1'b1;
					end
					zatr_pkg::OP_TICK: begin
						// BCD carry chain; 23:59:59 rolls over to midnight.
						if (tod_q.sc_lo != 4'd9) begin
							tod_q.sc_lo <= tod_q.sc_lo + 4'd1;
						end else begin
							tod_q.sc_lo <= 4'd0;
							if (tod_q.sc_hi != 3'd5) begin
								tod_q.sc_hi <= tod_q.sc_hi + 3'd1;
							end else begin
								tod_q.sc_hi <= 3'd0;
								if (tod_q.mn_lo != 4'd9) begin
									tod_q.mn_lo <= tod_q.mn_lo + 4'd1;
								end else begin
									tod_q.mn_lo <= 4'd0;
									if (tod_q.mn_hi != 3'd5) begin
										tod_q.mn_hi <= tod_q.mn_hi + 3'd1;
									end else begin
										tod_q.mn_hi <= 3'd0;
										if (tod_q.hr_hi == 2'd2 && tod_q.hr_lo == 4'd3) begin
											tod_q.hr_hi <= 2'd0;
											tod_q.hr_lo <= 4'd0;
										end else if (tod_q.hr_lo == 4'd9) begin
											tod_q.hr_lo <= 4'd0;
											tod_q.hr_hi <= tod_q.hr_hi + 2'd1;
										end else begin
											tod_q.hr_lo <= tod_q.hr_lo + 4'd1;
										end
									end
								end
							end
						end
					end
					zatr_pkg::OP_SWEEP: begin
						if (alarm_q) begin
							rising_q <= rising_next;
							period_q <= rising_next ? period_q + 8'd1 : period_q - 8'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### sv/zatr_fifo.sv
// Short command queue between the front end and the back end.
module zatr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  zatr_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output zatr_pkg::cmd_t pop_data,
	output logic           empty
);

	zatr_pkg::cmd_t                entries_q [zatr_pkg::FIFO_DEPTH];
	logic [zatr_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [zatr_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [zatr_pkg::FIFO_AW:0]    count_q;

	assign full     = (count_q == (zatr_pkg::FIFO_AW+1)'(zatr_pkg::FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/zatr_back.sv
// Back end: plays out queued commands as report characters or siren results.
module zatr_back (
	input  logic           clk,
	input  logic           arst_n,
	output logic           pop,
	input  zatr_pkg::cmd_t pop_data,
	input  logic           empty,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           byte_valid,
	output logic [7:0]     data_byte,
	output logic           last,
	output logic           siren_on,
	output logic [7:0]     siren_period,
	output logic [6:0]     siren_duty,
	output logic           alarm_active
);

	zatr_pkg::cmd_t cur_q;
	logic [3:0]     idx_q;
	logic           busy_q;
	logic           cur_done;
	logic           load;

	assign cur_done = !cur_q.is_report || (idx_q == zatr_pkg::REPORT_LAST);
	assign load     = !busy_q || (out_ready && cur_done);
	assign pop      = load && !empty;

	assign out_valid    = busy_q;
	assign byte_valid   = cur_q.is_report;
	assign data_byte    = cur_q.is_report ? zatr_pkg::report_char(cur_q, idx_q) : 8'd0;
	assign last         = cur_done;
	assign siren_on     = !cur_q.is_report && cur_q.siren_on;
	assign siren_period = cur_q.is_report ? 8'd0 : cur_q.period;
	assign siren_duty   = siren_period[7:1];
	assign alarm_active = cur_q.alarm;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= !empty;
				idx_q  <= '0;
			end else if (busy_q && out_ready) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

### sv/zone_alarm_time_stamp_reporter_top.sv
// Top level of the zone alarm reporter: front end, command queue and back end.
// A trigger or sweep step is queued, then loaded into the back end. A zone trigger
// holds the output for 16 beats, one report character per cycle while out_ready is
// high. A sweep step takes one beat and a tick none; the front end takes one item per
// cycle while the four-entry queue has room. Reset (arst_n low) is asynchronous and
// clears the clock to midnight, the alarm, the queue and restores the sweep registers.
module zone_alarm_time_stamp_reporter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [1:0] zone,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       siren_on,
	output logic [7:0] siren_period,
	output logic [6:0] siren_duty,
	output logic       alarm_active
);

	// Commands travel from the front end to the back end through the queue. The front
	// end updates all architectural state the moment an item is accepted, so a report
	// carries the time stamp and the sweep result carries the period seen at acceptance.
	zatr_pkg::cmd_t push_data;
	zatr_pkg::cmd_t pop_data;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	// Configuration flops take a write in any cycle; a sweep may override a start write.
	assign cfg_ready = 1'b1;

	zatr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.zone      (zone),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	zatr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The back end holds the current command in a register and steps through its
	// characters; it loads the next command in the same cycle its last beat is taken.
	zatr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_data     (pop_data),
		.empty        (empty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.last         (last),
		.siren_on     (siren_on),
		.siren_period (siren_period),
		.siren_duty   (siren_duty),
		.alarm_active (alarm_active)
	);

endmodule

### dv/tb_zone_alarm_time_stamp_reporter_top.sv
// Self-checking testbench for the zone alarm reporter: directed and random traffic.
module tb_zone_alarm_time_stamp_reporter_top;

	// Length of a day and of an hour in seconds, as the time stamp uses them.
	localparam int unsigned DAY_SECONDS  = 86400;
	localparam int unsigned HOUR_SECONDS = 3600;

	// Hard stop for the whole run. About 110 items, each at worst a report of
	// sixteen beats that each wait out the longest random receiver stall, plus the long
	// receiver stall and the settling before register writes, stay well below this.
	localparam int unsigned RUN_LIMIT = 100000;

	// Upper bound on how long the block may need to empty itself.
	localparam int unsigned DRAIN_LIMIT = 4000;

	// One output beat, field by field, as the block presents it.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       last;
		logic       siren_on;
		logic [7:0] siren_period;
		logic [6:0] siren_duty;
		logic       alarm_active;
	} beat_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] opcode;
	logic [1:0] zone;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       out_valid;
	logic       out_ready;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic       last;
	logic       siren_on;
	logic [7:0] siren_period;
	logic [6:0] siren_duty;
	logic       alarm_active;

	// Mirror of the alarm state: time of day, latch, zone, siren sweep and the
	// three sweep registers.
	int unsigned tod_secs;
	logic        alarm_on;
	logic [1:0]  zone_seen;
	logic [7:0]  siren_step;
	logic        sweeping_up;
	logic [7:0]  reg_low;
	logic [7:0]  reg_high;
	logic [7:0]  reg_start;

	// Beats the block still owes us, oldest first.
	beat_t beats_due[$];

	int unsigned mismatches;
	int unsigned beat_count;
	int unsigned cycle_count;

	// Idle controls shared by the sender task and the receiver process.
	bit          tx_idle_on;
	bit          rx_idle_on;
	int unsigned rx_stall_len;
	int unsigned rx_gap;

	beat_t got_beat;
	beat_t want_beat;

	zone_alarm_time_stamp_reporter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.zone         (zone),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.last         (last),
		.siren_on     (siren_on),
		.siren_period (siren_period),
		.siren_duty   (siren_duty),
		.alarm_active (alarm_active)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog. A hung handshake or a beat that never shows up ends here.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("zone_alarm_time_stamp_reporter_top: mismatch");
			$finish;
		end
	end

	// Prints one line per problem and counts every one.
	task automatic report_error(input string msg);
		mismatches++;
		$display("%s", msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_error($sformatf("beat %0d %s: got %0d, expected %0d",
				beat_count, name, got, want));
	endtask

	// Appends one expected beat. The alarm flag is taken after the item's update.
	function automatic void queue_beat(input logic bv, input logic [7:0] ch,
			input logic lst, input logic on, input logic [7:0] per);
		beat_t b;
		b.byte_valid   = bv;
		b.data_byte    = ch;
		b.last         = lst;
		b.siren_on     = on;
		b.siren_period = per;
		b.siren_duty   = per[7:1];
		b.alarm_active = alarm_on;
		beats_due.push_back(b);
	endfunction

	function automatic void reset_alarm_state();
		reg_low     = zatr_pkg::SWEEP_LOW_RESET;
		reg_high    = zatr_pkg::SWEEP_HIGH_RESET;
		reg_start   = zatr_pkg::SWEEP_START_RESET;
		tod_secs    = 0;
		alarm_on    = 1'b0;
		zone_seen   = 2'd0;
		siren_step  = zatr_pkg::SWEEP_START_RESET;
		sweeping_up = 1'b1;
	endfunction

	// Applies one accepted item to the mirrored state and lists the beats it causes.
	function automatic void alarm_step(input logic [1:0] op, input logic [1:0] zn);
		int unsigned hh;
		int unsigned mm;
		int unsigned ss;
		int          k;
		logic [7:0]  text[16];
		case (op)
			zatr_pkg::OP_TRIGGER: begin
				alarm_on  = 1'b1;
				zone_seen = zn;
				hh = tod_secs / HOUR_SECONDS;
				mm = (tod_secs % HOUR_SECONDS) / 60;
				ss = tod_secs % 60;
				text = '{zatr_pkg::CHR_Z, zatr_pkg::CHR_O, zatr_pkg::CHR_N,
					zatr_pkg::CHR_A, zatr_pkg::CHR_SPACE,
					zatr_pkg::CHR_ZERO + 8'(zone_seen), zatr_pkg::CHR_SPACE,
					zatr_pkg::CHR_ZERO + 8'(hh / 10), zatr_pkg::CHR_ZERO + 8'(hh % 10),
					zatr_pkg::CHR_COLON,
					zatr_pkg::CHR_ZERO + 8'(mm / 10), zatr_pkg::CHR_ZERO + 8'(mm % 10),
					zatr_pkg::CHR_COLON,
					zatr_pkg::CHR_ZERO + 8'(ss / 10), zatr_pkg::CHR_ZERO + 8'(ss % 10),
					zatr_pkg::CHR_CR};
				for (k = 0; k < 16; k++)
					queue_beat(1'b1, text[k], k == 15, 1'b0, 8'd0);
			end
			zatr_pkg::OP_TICK: begin
				tod_secs = (tod_secs == DAY_SECONDS - 1) ? 0 : tod_secs + 1;
			end
			zatr_pkg::OP_SWEEP: begin
				if (alarm_on) begin
					// Report the current period first, then turn at the bounds and move.
					queue_beat(1'b0, 8'd0, 1'b1, 1'b1, siren_step);
					if (siren_step > reg_high)
						sweeping_up = 1'b0;
					else if (siren_step < reg_low)
						sweeping_up = 1'b1;
					siren_step = sweeping_up ? siren_step + 8'd1 : siren_step - 8'd1;
				end else begin
					queue_beat(1'b0, 8'd0, 1'b1, 1'b0, 8'd0);
				end
			end
			default: begin
				// The unused opcode leaves everything as it was.
			end
		endcase
	endfunction

	// Output checker. Every accepted beat is held against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_beat = {byte_valid, data_byte, last, siren_on, siren_period,
				siren_duty, alarm_active};
			if (beats_due.size() == 0) begin
				report_error($sformatf("beat %0d arrived with nothing expected", beat_count));
			end else begin
				want_beat = beats_due.pop_front();
				check_field("byte_valid", got_beat.byte_valid, want_beat.byte_valid);
				check_field("data_byte", got_beat.data_byte, want_beat.data_byte);
				check_field("last", got_beat.last, want_beat.last);
				check_field("siren_on", got_beat.siren_on, want_beat.siren_on);
				check_field("siren_period", got_beat.siren_period, want_beat.siren_period);
				check_field("siren_duty", got_beat.siren_duty, want_beat.siren_duty);
				check_field("alarm_active", got_beat.alarm_active, want_beat.alarm_active);
			end
			beat_count++;
		end
	end

	// Receiver. Before each beat it draws a short wait, unless a test has asked
	// for a long stall, which is counted out here in cycles. A stall request also
	// breaks the wait for a beat, so it takes effect even when the output is quiet.
	always begin
		@(negedge clk);
		if (rx_stall_len > 0) begin
			rx_gap = rx_stall_len;
			rx_stall_len = 0;
		end else begin
			rx_gap = rx_idle_on ? $urandom_range(0, 6) : 0;
		end
		if (rx_gap > 0) begin
			out_ready <= 1'b0;
			repeat (rx_gap) @(negedge clk);
		end
		out_ready <= 1'b1;
		do @(posedge clk); while (!out_valid && rx_stall_len == 0);
	end

	// Sends one input beat. It returns at the rising edge where the beat was taken,
	// with valid still high, so that a following call can send back to back. A test
	// that stops sending calls end_burst to drop valid.
	task automatic send_item(input logic [1:0] op, input logic [1:0] zn);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		zone     <= zn;
		do @(posedge clk); while (!in_ready);
		alarm_step(op, zn);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Mostly triggers and sweep steps, some ticks and a few unused opcodes.
	task automatic send_random_item();
		int unsigned pick;
		logic [1:0]  op;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = zatr_pkg::OP_TRIGGER;
		else if (pick < 45)
			op = zatr_pkg::OP_TICK;
		else if (pick < 90)
			op = zatr_pkg::OP_SWEEP;
		else
			op = zatr_pkg::OP_NONE;
		send_item(op, 2'($urandom_range(0, 3)));
	endtask

	task automatic wait_drained();
		int unsigned n;
		n = 0;
		while (beats_due.size() > 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Brings the block to rest before a register write. Ticks and unused opcodes
	// leave no beat behind, so the task also waits on past the last owed beat.
	task automatic settle();
		wait_drained();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			zatr_pkg::CFG_SWEEP_LOW:  reg_low = val;
			zatr_pkg::CFG_SWEEP_HIGH: reg_high = val;
			zatr_pkg::CFG_SWEEP_START: begin
				// A start write also reloads the running period.
				reg_start  = val;
				siren_step = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Before any trigger: the siren must report off, ticks and the unused opcode
	// must stay silent. Zone is varied although these opcodes ignore it.
	task automatic test_siren_off();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_item(zatr_pkg::OP_SWEEP, 2'd3);
		send_item(zatr_pkg::OP_NONE, 2'd0);
		send_item(zatr_pkg::OP_TICK, 2'd2);
		send_item(zatr_pkg::OP_SWEEP, 2'd1);
		send_item(zatr_pkg::OP_NONE, 2'd3);
		send_item(zatr_pkg::OP_TICK, 2'd0);
		send_item(zatr_pkg::OP_SWEEP, 2'd0);
		end_burst();
	endtask

	// Reports for every zone value, zone zero among them, at a few times of day.
	// Both sides run without idling here, so the reports go out back to back.
	task automatic test_report_zones();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_item(zatr_pkg::OP_TRIGGER, 2'd0);
		send_item(zatr_pkg::OP_TICK, 2'd1);
		send_item(zatr_pkg::OP_TICK, 2'd3);
		send_item(zatr_pkg::OP_TRIGGER, 2'd1);
		send_item(zatr_pkg::OP_TRIGGER, 2'd2);
		send_item(zatr_pkg::OP_TICK, 2'd0);
		send_item(zatr_pkg::OP_TRIGGER, 2'd3);
		send_item(zatr_pkg::OP_SWEEP, 2'd2);
		send_item(zatr_pkg::OP_NONE, 2'd1);
		send_item(zatr_pkg::OP_SWEEP, 2'd3);
		end_burst();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// reports and sweep steps, so the command queue fills and input stalls.
	task automatic test_backpressure();
		int i;
		tx_idle_on   = 1'b0;
		rx_idle_on   = 1'b1;
		rx_stall_len = 150;
		for (i = 0; i < 12; i++)
			send_item((i % 3 == 2) ? zatr_pkg::OP_SWEEP : zatr_pkg::OP_TRIGGER,
				2'($urandom_range(0, 3)));
		end_burst();
	endtask

	// The sender stops until every owed beat has come, then starts again.
	task automatic test_drain_pause();
		int i;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (i = 0; i < 5; i++)
			send_random_item();
		end_burst();
		wait_drained();
		for (i = 0; i < 5; i++)
			send_random_item();
		end_burst();
	endtask

	// One random phase under a given sweep setting, written while the block rests.
	task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi,
			input logic [7:0] st, input int n_items);
		int i;
		settle();
		write_reg(zatr_pkg::CFG_SWEEP_LOW, lo);
		write_reg(zatr_pkg::CFG_SWEEP_HIGH, hi);
		write_reg(zatr_pkg::CFG_SWEEP_START, st);
		tx_idle_on = $urandom_range(0, 1);
		rx_idle_on = $urandom_range(0, 1);
		for (i = 0; i < n_items; i++)
			send_random_item();
		end_burst();
	endtask

	// Sweep settings at the extremes of the register ranges, tight windows where
	// the sweep turns every few steps, then random windows, last the reset values.
	task automatic test_sweep_settings();
		int          i;
		int unsigned lo;
		int unsigned hi;
		int unsigned st;
		run_phase(8'd1, 8'd254, 8'd0, 7);
		run_phase(8'd254, 8'd1, 8'd255, 7);
		run_phase(8'd1, 8'd1, 8'd3, 7);
		run_phase(8'd254, 8'd254, 8'd251, 7);
		run_phase(8'd120, 8'd124, 8'd118, 7);
		for (i = 0; i < 3; i++) begin
			lo = $urandom_range(1, 254);
			hi = lo + $urandom_range(0, 8);
			if (hi > 254)
				hi = 254;
			st = (lo > 4) ? lo - 4 : 0;
			run_phase(8'(lo), 8'(hi), 8'(st), 6);
		end
		run_phase(zatr_pkg::SWEEP_LOW_RESET, zatr_pkg::SWEEP_HIGH_RESET,
			zatr_pkg::SWEEP_START_RESET, 6);
	endtask

	// Reports taken around a run of ticks long enough to carry the seconds tens
	// digit, then once more after a single tick.
	task automatic test_clock_carry();
		int unsigned n;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_item(zatr_pkg::OP_TRIGGER, 2'd1);
		for (n = 0; n < 10; n++)
			send_item(zatr_pkg::OP_TICK, 2'(n));
		send_item(zatr_pkg::OP_TRIGGER, 2'd2);
		send_item(zatr_pkg::OP_TICK, 2'd0);
		send_item(zatr_pkg::OP_TRIGGER, 2'd3);
		end_burst();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = zatr_pkg::OP_NONE;
		zone         = 2'd0;
		cfg_valid    = 1'b0;
		cfg_index    = zatr_pkg::CFG_SWEEP_LOW;
		cfg_data     = 8'd0;
		out_ready    = 1'b0;
		mismatches   = 0;
		beat_count   = 0;
		cycle_count  = 0;
		tx_idle_on   = 1'b0;
		rx_idle_on   = 1'b0;
		rx_stall_len = 0;
		reset_alarm_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_siren_off();
		test_report_zones();
		test_backpressure();
		test_drain_pause();
		test_sweep_settings();
		test_clock_carry();

		// Let the last beats out, then a few quiet cycles for anything stray.
		wait_drained();
		repeat (16) @(posedge clk);
		if (beats_due.size() != 0)
			report_error($sformatf("%0d beats never arrived", beats_due.size()));
		if (mismatches == 0)
			$display("zone_alarm_time_stamp_reporter_top: match");
		else
			$display("zone_alarm_time_stamp_reporter_top: mismatch");
		$finish;
	end

endmodule

### filelist.f
sv/zatr_pkg.sv
sv/zatr_front.sv
sv/zatr_fifo.sv
sv/zatr_back.sv
sv/zone_alarm_time_stamp_reporter_top.sv
dv/tb_zone_alarm_time_stamp_reporter_top.sv
